// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/e2q_pkg.sv -----
// Types, constants and helper functions of the Euler-to-quaternion block.
package e2q_pkg;

    localparam int ANG_W  = 16;   // input binary angle width
    localparam int Q_W    = 16;   // output Q1.14 width
    localparam int XY_W   = 33;   // CORDIC vector, Q30 plus growth and sign
    localparam int CS_W   = 22;   // gain-corrected sine/cosine, Q20
    localparam int PAIR_W = 2 * CS_W;        // product of two Q20 factors
    localparam int SPLIT  = 21;              // low slice of a pair product
    localparam int HI_W   = PAIR_W - SPLIT + CS_W;
    localparam int LO_W   = SPLIT + 1 + CS_W;
    localparam int TERM_W = 66;              // Q60 triple product with headroom
    localparam int ATAN_LEN = 24;

    localparam logic signed [30:0] GAIN_Q30  = 31'sd652032874;
    localparam logic signed [63:0] GAIN_RND  = 64'sh0000_0080_0000_0000;
    localparam logic signed [TERM_W-1:0] Q14_RND = TERM_W'(64'sh0000_2000_0000_0000);
    localparam logic signed [19:0] Q_MAX = 20'sd16384;

    // Arctangent of 2^-i, 2^32 is a full turn.
    localparam logic [31:0] ATAN_FULL32 [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [ANG_W-1:0] roll_angle;
        logic signed [ANG_W-1:0] pitch_angle;
        logic signed [ANG_W-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [Q_W-1:0] quat_w;
        logic signed [Q_W-1:0] quat_x;
        logic signed [Q_W-1:0] quat_y;
        logic signed [Q_W-1:0] quat_z;
    } t_quat;

    // Cosine and sine of a half angle, Q20.
    typedef struct packed {
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_sincos;

    // Table entry rounded half up to residual units (pi/2 = 2^(aw-1)).
    function automatic logic [31:0] atan_entry(input int idx, input int aw);
        logic [32:0] t;
        int          s;
        s = 31 - aw;
        t = {1'b0, ATAN_FULL32[idx]};
        if (s > 0) begin
            t = (t + (33'd1 << (s - 1))) >> s;
        end
        return t[31:0];
    endfunction

endpackage

// ----- hdl/euler_to_quaternion_top.sv -----
// Top level of the Euler-angle (ZYX) to unit-quaternion converter.
// Converts roll/pitch/yaw binary angles (16-bit signed, 32768 = pi) into a
// unit quaternion in signed Q1.14, each component saturated to +/-16384.
// Each result depends only on its own angle triple. The block takes one
// angle triple per clock while o_ready is high. Three parallel CORDIC
// pipelines, one stage per micro-rotation, come first; gain correction adds
// two stages, the product and sum network five, and the output register
// one. An output register plus a one-entry skid buffer keep the pipeline
// moving while a finished result waits; o_ready is registered and drops
// only once the skid entry is full.
`include "assert_macros.svh"

module euler_to_quaternion_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_WIDTH  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_ready,
    input  e2q_pkg::t_angles i_angles,
    // output channel
    output logic             o_valid,
    input  logic             i_ready,
    output e2q_pkg::t_quat   o_quat
);

    // Whole pipeline moves together; it holds only when the skid entry is full.
    logic advance;

    logic             r_out_valid;
    e2q_pkg::t_quat   r_out;
    logic             r_skid_valid;
    e2q_pkg::t_quat   r_skid;

    assign advance = !r_skid_valid;
    assign o_ready = advance;

    // Half-angle sine/cosine for each axis
    logic             cv_x, cv_y, cv_z;
    e2q_pkg::t_sincos sc_x, sc_y, sc_z;

    e2q_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_cordic_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (i_valid),
        .i_angle (i_angles.roll_angle),
        .o_valid (cv_x),
        .o_sc    (sc_x)
    );

    e2q_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_cordic_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (i_valid),
        .i_angle (i_angles.pitch_angle),
        .o_valid (cv_y),
        .o_sc    (sc_y)
    );

    e2q_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_cordic_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (i_valid),
        .i_angle (i_angles.yaw_angle),
        .o_valid (cv_z),
        .o_sc    (sc_z)
    );

    // Triple-product sums; the three CORDIC lanes run in lockstep
    logic           p_valid;
    e2q_pkg::t_quat p_quat;

    e2q_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (cv_x),
        .i_sc_x  (sc_x),
        .i_sc_y  (sc_y),
        .i_sc_z  (sc_z),
        .o_valid (p_valid),
        .o_quat  (p_quat)
    );

    // Output register and skid entry
    logic out_free;
    logic p_leave;

    assign out_free = !r_out_valid || i_ready;
    assign p_leave  = advance && p_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || p_leave;
            r_skid_valid <= 1'b0;
        end else if (p_leave) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : p_quat;
        end else if (p_leave) begin
            r_skid <= p_quat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_quat  = r_out;

    // The skid entry fills only behind a held output
    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry full while output register empty")
    // A stalled pipeline keeps its last stage
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !advance, $stable(p_valid) && $stable(p_quat),
        "pipeline moved during stall")
    // Lanes stay aligned
    `ASSERT_IMPLIES(a_lanes_aligned, i_clk, i_rst_n, 1'b1, (cv_x == cv_y) && (cv_y == cv_z),
        "CORDIC lanes out of step")
    // Saturated range on the scalar part
    `ASSERT_IMPLIES(a_w_range, i_clk, i_rst_n, o_valid,
        (o_quat.quat_w <= 16'sd16384) && (o_quat.quat_w >= -16'sd16384),
        "quat_w outside unit range")

endmodule

// ----- hdl/e2q_cordic.sv -----
// Pipelined rotation-mode CORDIC giving gain-corrected cos/sin of a half angle.
module e2q_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_WIDTH  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [e2q_pkg::ANG_W-1:0]     i_angle,
    output logic                                 o_valid,
    output e2q_pkg::t_sincos                     o_sc
);

    localparam int N  = (CORDIC_STEPS > e2q_pkg::ATAN_LEN) ? e2q_pkg::ATAN_LEN : CORDIC_STEPS;
    localparam int ZW = ANGLE_WIDTH + 2;
    localparam int XW = e2q_pkg::XY_W;
    localparam logic signed [XW-1:0] X_INIT = XW'(64'sd1073741824);

    logic                 r_v [0:N];
    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];

    logic signed [31:0]   ang32;
    logic signed [31:0]   z_scaled;
    logic signed [ZW-1:0] n_z0;

    assign ang32 = 32'(i_angle);

    generate
        if (ANGLE_WIDTH >= e2q_pkg::ANG_W) begin : g_up
            assign z_scaled = ang32 <<< (ANGLE_WIDTH - e2q_pkg::ANG_W);
        end else begin : g_down
            assign z_scaled = ang32 >>> (e2q_pkg::ANG_W - ANGLE_WIDTH);
        end
    endgenerate

    assign n_z0 = z_scaled[ZW-1:0];

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= X_INIT;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
        end
    end

    // One micro-rotation per stage
    generate
        for (genvar k = 0; k < N; k++) begin : g_step
            localparam logic [31:0] ATAN_K = e2q_pkg::atan_entry(k, ANGLE_WIDTH);
            localparam logic signed [ZW-1:0] ATAN_Z = $signed({1'b0, ATAN_K[ZW-2:0]});

            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            assign dx = r_y[k] >>> k;
            assign dy = r_x[k] >>> k;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= r_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[k][ZW-1]) begin
                        r_x[k+1] <= r_x[k] - dx;
                        r_y[k+1] <= r_y[k] + dy;
                        r_z[k+1] <= r_z[k] - ATAN_Z;
                    end else begin
                        r_x[k+1] <= r_x[k] + dx;
                        r_y[k+1] <= r_y[k] - dy;
                        r_z[k+1] <= r_z[k] + ATAN_Z;
                    end
                end
            end
        end
    endgenerate

    // Gain correction: multiply, then round half up to Q20
    logic               r_vg1;
    logic               r_vg2;
    logic signed [63:0] r_pc;
    logic signed [63:0] r_ps;
    logic signed [63:0] rnd_c;
    logic signed [63:0] rnd_s;
    e2q_pkg::t_sincos   r_sc;

    assign rnd_c = r_pc + e2q_pkg::GAIN_RND;
    assign rnd_s = r_ps + e2q_pkg::GAIN_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg1 <= 1'b0;
            r_vg2 <= 1'b0;
        end else if (i_en) begin
            r_vg1 <= r_v[N];
            r_vg2 <= r_vg1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc   <= r_x[N] * e2q_pkg::GAIN_Q30;
            r_ps   <= r_y[N] * e2q_pkg::GAIN_Q30;
            r_sc.c <= rnd_c[40 +: e2q_pkg::CS_W];
            r_sc.s <= rnd_s[40 +: e2q_pkg::CS_W];
        end
    end

    assign o_valid = r_vg2;
    assign o_sc    = r_sc;

endmodule

// ----- hdl/e2q_combine.sv -----
// Pipelined triple-product sums forming the quaternion from half-angle cos/sin.
module e2q_combine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  e2q_pkg::t_sincos i_sc_x,
    input  e2q_pkg::t_sincos i_sc_y,
    input  e2q_pkg::t_sincos i_sc_z,
    output logic             o_valid,
    output e2q_pkg::t_quat   o_quat
);

    localparam int CW    = e2q_pkg::CS_W;
    localparam int PW    = e2q_pkg::PAIR_W;
    localparam int SP    = e2q_pkg::SPLIT;
    localparam int TW    = e2q_pkg::TERM_W;
    localparam int Q_W_L = e2q_pkg::Q_W;

    logic r_v [1:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 5; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int i = 2; i <= 5; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    // Stage 1: yaw/pitch pair products
    logic signed [PW-1:0] r_pcc, r_pss, r_pcs, r_psc;
    logic signed [CW-1:0] r_cx, r_sx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pcc <= i_sc_z.c * i_sc_y.c;
            r_pss <= i_sc_z.s * i_sc_y.s;
            r_pcs <= i_sc_z.c * i_sc_y.s;
            r_psc <= i_sc_z.s * i_sc_y.c;
            r_cx  <= i_sc_x.c;
            r_sx  <= i_sc_x.s;
        end
    end

    // Stage 2: each pair times the roll factor, split in two partial products
    logic signed [PW-1:0] pa [0:7];
    logic signed [CW-1:0] pb [0:7];

    assign pa[0] = r_pcc;  assign pb[0] = r_cx;   // w
    assign pa[1] = r_pss;  assign pb[1] = r_sx;
    assign pa[2] = r_pcc;  assign pb[2] = r_sx;   // x
    assign pa[3] = r_pss;  assign pb[3] = r_cx;
    assign pa[4] = r_pcs;  assign pb[4] = r_cx;   // y
    assign pa[5] = r_psc;  assign pb[5] = r_sx;
    assign pa[6] = r_psc;  assign pb[6] = r_cx;   // z
    assign pa[7] = r_pcs;  assign pb[7] = r_sx;

    logic signed [e2q_pkg::HI_W-1:0] r_hi   [0:7];
    logic signed [e2q_pkg::LO_W-1:0] r_lo   [0:7];
    logic signed [TW-1:0]            r_term [0:7];

    generate
        for (genvar j = 0; j < 8; j++) begin : g_term
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_hi[j]   <= $signed(pa[j][PW-1:SP]) * pb[j];
                    r_lo[j]   <= $signed({1'b0, pa[j][SP-1:0]}) * pb[j];
                    r_term[j] <= (TW'(r_hi[j]) <<< SP) + TW'(r_lo[j]);
                end
            end
        end
    endgenerate

    // Stage 4: sums, stage 5: round half up to Q14 and saturate
    logic signed [TW-1:0]        r_sum [0:3];
    logic signed [Q_W_L-1:0]     r_q   [0:3];

    generate
        for (genvar k = 0; k < 4; k++) begin : g_sum
            localparam bit SUB = (k == 1) || (k == 3);
            logic signed [TW-1:0] rnd;
            logic signed [19:0]   v;
            assign rnd = r_sum[k] + e2q_pkg::Q14_RND;
            assign v   = rnd[65:46];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sum[k] <= SUB ? (r_term[2*k] - r_term[2*k+1])
                                    : (r_term[2*k] + r_term[2*k+1]);
                    if (v > e2q_pkg::Q_MAX) begin
                        r_q[k] <= Q_W_L'(e2q_pkg::Q_MAX);
                    end else if (v < -e2q_pkg::Q_MAX) begin
                        r_q[k] <= Q_W_L'(-e2q_pkg::Q_MAX);
                    end else begin
                        r_q[k] <= v[Q_W_L-1:0];
                    end
                end
            end
        end
    endgenerate

    assign o_valid       = r_v[5];
    assign o_quat.quat_w = r_q[0];
    assign o_quat.quat_x = r_q[1];
    assign o_quat.quat_y = r_q[2];
    assign o_quat.quat_z = r_q[3];

endmodule
